// ----- rtl/core/tafc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature alarm and fan controller package
// Shared payload types, key and alarm codes, limits and reset values.
// ----------------------------------------------------------------------------
package tafc_pkg;

  localparam int DUTY_W             = 7;
  localparam int PWM_PERIOD_DEFAULT = 100;

  localparam logic signed [7:0] HIGH_MAX   = 8'sd125;
  localparam logic signed [7:0] LOW_MIN    = -8'sd55;
  localparam logic signed [7:0] HIGH_RESET = 8'sd30;
  localparam logic signed [7:0] LOW_RESET  = 8'sd20;
  localparam logic [DUTY_W-1:0] FAN_DUTY_RESET = 7'd60;

  // Item kinds.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Pad key codes.
  localparam logic [2:0] PAD_NONE      = 3'd0;
  localparam logic [2:0] PAD_HIGH_UP   = 3'd1;
  localparam logic [2:0] PAD_HIGH_DOWN = 3'd2;
  localparam logic [2:0] PAD_LOW_UP    = 3'd3;
  localparam logic [2:0] PAD_LOW_DOWN  = 3'd4;
  localparam logic [2:0] PAD_FAN_MODE  = 3'd7;

  // Button key codes.
  localparam logic [2:0] BTN_NONE    = 3'd0;
  localparam logic [2:0] BTN_AUDIBLE = 3'd1;
  localparam logic [2:0] BTN_SILENT  = 3'd2;
  localparam logic [2:0] BTN_AUTO    = 3'd4;

  // Alarm classes and beep requests.
  localparam logic [1:0] ALARM_NONE = 2'd0;
  localparam logic [1:0] ALARM_HIGH = 2'd1;
  localparam logic [1:0] ALARM_LOW  = 2'd2;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_HIGH = 2'd1;
  localparam logic [1:0] BEEP_LOW  = 2'd2;

  typedef struct packed {
    logic              command;
    logic signed [11:0] temperature;
    logic [2:0]        pad_key;
    logic [2:0]        button_key;
  } item_t;

  typedef struct packed {
    logic              motor_on;
    logic [1:0]        alarm_class;
    logic              key_beep;
    logic [1:0]        alarm_beep;
    logic signed [7:0] high_limit;
    logic signed [7:0] low_limit;
    logic              silent_flag;
    logic              auto_flag;
  } result_t;

  // Controller state apart from the PWM counter, whose width follows the period.
  typedef struct packed {
    logic signed [7:0]  high;
    logic signed [7:0]  low;
    logic               silenced;
    logic               auto_mode;
    logic [DUTY_W-1:0]  duty;
    logic [1:0]         last_alarm;
  } state_t;

endpackage

// ----- rtl/core/tafc_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one request per cycle while the sink holds ready, with a payload of any packed type.
// ----------------------------------------------------------------------------
interface tafc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/tafc_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Controller step logic
// Computes the next state and the result for one tick or control request.
// ----------------------------------------------------------------------------
module tafc_step #(
  parameter int PWM_PERIOD = tafc_pkg::PWM_PERIOD_DEFAULT,
  parameter int CNT_W      = $clog2(PWM_PERIOD)
) (
  input  tafc_pkg::item_t                 item,
  input  tafc_pkg::state_t                st,
  input  logic [CNT_W-1:0]                cnt,
  input  logic [tafc_pkg::DUTY_W-1:0]     fan_duty,
  output tafc_pkg::state_t                st_next,
  output logic [CNT_W-1:0]                cnt_next,
  output tafc_pkg::result_t               res
);

  localparam int CW1 = CNT_W + 1;

  logic [CW1-1:0]     cnt_inc;
  logic signed [8:0]  high9;
  logic signed [8:0]  low9;
  logic signed [8:0]  high_dec;
  logic signed [8:0]  low_inc;
  logic signed [7:0]  high_new;
  logic signed [7:0]  low_new;
  logic signed [12:0] temp13;
  logic signed [12:0] high_scaled;
  logic signed [12:0] low_scaled;
  logic               silenced_new;
  logic               auto_new;
  logic               key_beep;
  logic [1:0]         alarm_beep;

  always_comb begin
    high9       = {st.high[7], st.high};
    low9        = {st.low[7], st.low};
    high_dec    = high9 - 9'sd1;
    low_inc     = low9 + 9'sd1;
    cnt_inc     = {1'b0, cnt} + CW1'(1);
    high_new    = st.high;
    low_new     = st.low;
    silenced_new = st.silenced;
    auto_new    = st.auto_mode;
    key_beep    = 1'b0;
    alarm_beep  = tafc_pkg::BEEP_NONE;
    st_next     = st;
    cnt_next    = cnt;
    temp13      = {item.temperature[11], item.temperature};
    high_scaled = '0;
    low_scaled  = '0;

    if (item.command == tafc_pkg::CMD_TICK) begin
      cnt_next = (cnt_inc >= CW1'(PWM_PERIOD)) ? '0 : cnt_inc[CNT_W-1:0];
    end else begin
      unique case (item.pad_key)
        tafc_pkg::PAD_HIGH_UP: begin
          if (st.high < tafc_pkg::HIGH_MAX) high_new = st.high + 8'sd1;
        end
        tafc_pkg::PAD_HIGH_DOWN: begin
          // Keep the high threshold strictly above the low one.
          if (high_dec > low9) high_new = high_dec[7:0];
        end
        tafc_pkg::PAD_LOW_UP: begin
          if (low_inc < high9) low_new = low_inc[7:0];
        end
        tafc_pkg::PAD_LOW_DOWN: begin
          if (st.low > tafc_pkg::LOW_MIN) low_new = st.low - 8'sd1;
        end
        tafc_pkg::PAD_FAN_MODE: begin
          auto_new = 1'b0;
        end
        default: begin
        end
      endcase

      unique case (item.button_key)
        tafc_pkg::BTN_AUDIBLE: begin
          silenced_new = 1'b0;
          key_beep     = 1'b1;
        end
        tafc_pkg::BTN_SILENT: begin
          silenced_new = 1'b1;
          key_beep     = 1'b1;
        end
        tafc_pkg::BTN_AUTO: begin
          auto_new = 1'b1;
        end
        default: begin
        end
      endcase

      // Thresholds are whole degrees; samples are sixteenths.
      high_scaled = {high_new[7], high_new, 4'b0000};
      low_scaled  = {low_new[7], low_new, 4'b0000};

      st_next.high      = high_new;
      st_next.low       = low_new;
      st_next.silenced  = silenced_new;
      st_next.auto_mode = auto_new;

      priority if (!silenced_new && temp13 > high_scaled) begin
        st_next.last_alarm = tafc_pkg::ALARM_HIGH;
        alarm_beep         = tafc_pkg::BEEP_HIGH;
        st_next.duty       = auto_new ? '0 : fan_duty;
      end else if (!silenced_new && temp13 < low_scaled) begin
        st_next.last_alarm = tafc_pkg::ALARM_LOW;
        alarm_beep         = tafc_pkg::BEEP_LOW;
        st_next.duty       = '0;
      end else begin
        st_next.last_alarm = tafc_pkg::ALARM_NONE;
        st_next.duty       = '0;
      end
    end

    res.motor_on    = tafc_pkg::DUTY_W'(cnt_next) < st_next.duty;
    res.alarm_class = st_next.last_alarm;
    res.key_beep    = key_beep;
    res.alarm_beep  = alarm_beep;
    res.high_limit  = st_next.high;
    res.low_limit   = st_next.low;
    res.silent_flag = st_next.silenced;
    res.auto_flag   = st_next.auto_mode;
  end

endmodule

// ----- rtl/core/temperature_alarm_fan_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature alarm and fan controller
// Threshold alarm with key handling and a PWM fan drive.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and returns one result for each
// request. A request is latched in an input register; when the result register
// is free or being emptied, the step logic updates the thresholds, modes, duty
// and PWM counter and loads the result register, which then offers the result.
// The result register can hold a finished result while a new request sits in
// the input register, and requests keep flowing at one per cycle as long as
// results are taken. The fan duty register accepts a write in every cycle and
// should only be written while no request is in flight.
module temperature_alarm_fan_controller_unit #(
  parameter int PWM_PERIOD = tafc_pkg::PWM_PERIOD_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  tafc_stream_if.sink   item,
  tafc_stream_if.source result,
  tafc_stream_if.sink   cfg
);

  localparam int CNT_W = $clog2(PWM_PERIOD);

  logic                          s1_valid;
  tafc_pkg::item_t               s1_data;
  logic                          advance;
  logic                          out_valid;
  tafc_pkg::result_t             out_data;
  tafc_pkg::state_t              st;
  tafc_pkg::state_t              st_next;
  logic [CNT_W-1:0]              cnt;
  logic [CNT_W-1:0]              cnt_next;
  logic [tafc_pkg::DUTY_W-1:0]   fan_duty;
  tafc_pkg::result_t             res;

  assign advance      = s1_valid && (!out_valid || result.ready);
  assign item.ready   = !s1_valid || advance;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  tafc_step #(
    .PWM_PERIOD (PWM_PERIOD),
    .CNT_W      (CNT_W)
  ) u_step (
    .item     (s1_data),
    .st       (st),
    .cnt      (cnt),
    .fan_duty (fan_duty),
    .st_next  (st_next),
    .cnt_next (cnt_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_duty <= tafc_pkg::FAN_DUTY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      fan_duty <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_data <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.high       <= tafc_pkg::HIGH_RESET;
      st.low        <= tafc_pkg::LOW_RESET;
      st.silenced   <= 1'b0;
      st.auto_mode  <= 1'b1;
      st.duty       <= '0;
      st.last_alarm <= tafc_pkg::ALARM_NONE;
      cnt           <= '0;
    end else if (advance) begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  // The thresholds never cross and stay inside the clamp range.
  a_limits_ordered: assert property (@(posedge clk) disable iff (rst)
    st.high > st.low)
    else $error("high threshold not above low threshold");

  a_limits_range: assert property (@(posedge clk) disable iff (rst)
    st.high <= tafc_pkg::HIGH_MAX && st.low >= tafc_pkg::LOW_MIN)
    else $error("threshold outside clamp range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cnt} < (CNT_W + 1)'(PWM_PERIOD))
    else $error("PWM counter outside period");

  a_silent_no_beep: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.silent_flag |-> out_data.alarm_beep == tafc_pkg::BEEP_NONE)
    else $error("alarm beep while silenced");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> s1_valid)
    else $error("accepted request lost from input register");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature alarm and fan controller testbench
// Drives PWM ticks and control steps through the request channel, writes the
// fan duty register between phases, and checks every result against a
// predictor of the thresholds, alarm, beep and PWM behavior.
// ----------------------------------------------------------------------------
import tafc_pkg::*;

class fan_alarm_tracker;
  localparam int PWM_PERIOD = PWM_PERIOD_DEFAULT;

  int       fan_duty;
  int       high_deg;
  int       low_deg;
  logic     silenced;
  logic     auto_mode;
  int       duty;
  int       pwm_count;
  logic [1:0] last_alarm;
  result_t  expected_results[$];
  int       mismatches;

  function new();
    fan_duty   = FAN_DUTY_RESET;
    high_deg   = HIGH_RESET;
    low_deg    = LOW_RESET;
    silenced   = 1'b0;
    auto_mode  = 1'b1;
    duty       = 0;
    pwm_count  = 0;
    last_alarm = ALARM_NONE;
    mismatches = 0;
  endfunction

  function void write_duty(logic [DUTY_W-1:0] value);
    fan_duty = value;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Works out the result of one accepted request and updates the state.
  function void note_request(item_t req);
    result_t    want;
    int         temp;
    logic       key_beep;
    logic [1:0] beep;
    key_beep = 1'b0;
    beep = BEEP_NONE;
    if (req.command == CMD_TICK) begin
      pwm_count = (pwm_count + 1) % 128;
      if (pwm_count >= PWM_PERIOD) pwm_count = 0;
    end else begin
      temp = $signed(req.temperature);
      case (req.pad_key)
        PAD_HIGH_UP:   if (high_deg < HIGH_MAX) high_deg++;
        PAD_HIGH_DOWN: if (high_deg - 1 > low_deg) high_deg--;
        PAD_LOW_UP:    if (low_deg + 1 < high_deg) low_deg++;
        PAD_LOW_DOWN:  if (low_deg > LOW_MIN) low_deg--;
        PAD_FAN_MODE:  auto_mode = 1'b0;
        default: ;
      endcase
      case (req.button_key)
        BTN_AUDIBLE: begin
          silenced = 1'b0;
          key_beep = 1'b1;
        end
        BTN_SILENT: begin
          silenced = 1'b1;
          key_beep = 1'b1;
        end
        BTN_AUTO: begin
          auto_mode = 1'b1;
          duty = 0;
        end
        default: ;
      endcase
      if (!silenced && temp > high_deg * 16) begin
        last_alarm = ALARM_HIGH;
        beep = BEEP_HIGH;
        duty = auto_mode ? 0 : fan_duty;
      end else if (!silenced && temp < low_deg * 16) begin
        last_alarm = ALARM_LOW;
        beep = BEEP_LOW;
        duty = 0;
      end else begin
        last_alarm = ALARM_NONE;
        duty = 0;
      end
    end
    want.motor_on    = (pwm_count < duty);
    want.alarm_class = last_alarm;
    want.key_beep    = key_beep;
    want.alarm_beep  = beep;
    want.high_limit  = 8'(high_deg);
    want.low_limit   = 8'(low_deg);
    want.silent_flag = silenced;
    want.auto_flag   = auto_mode;
    expected_results.push_back(want);
  endfunction

  function void compare_field(string field, logic signed [31:0] want,
                              logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with no request pending, expected none, actual %p", $time, got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("motor_on", want.motor_on, got.motor_on);
    compare_field("alarm_class", want.alarm_class, got.alarm_class);
    compare_field("key_beep", want.key_beep, got.key_beep);
    compare_field("alarm_beep", want.alarm_beep, got.alarm_beep);
    compare_field("high_limit", $signed(want.high_limit), $signed(got.high_limit));
    compare_field("low_limit", $signed(want.low_limit), $signed(got.low_limit));
    compare_field("silent_flag", want.silent_flag, got.silent_flag);
    compare_field("auto_flag", want.auto_flag, got.auto_flag);
  endfunction
endclass

module tb;
  localparam int PWM_PERIOD  = PWM_PERIOD_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 275;
  localparam int SEGMENT_ITEMS = 100;

  typedef enum {DRIFT_HIGH_UP, DRIFT_LOW_DOWN, DRIFT_SQUEEZE, DRIFT_MIXED} drift_e;

  logic clk = 1'b0;
  logic rst;

  tafc_stream_if #(.payload_t(item_t))             req_ch ();
  tafc_stream_if #(.payload_t(result_t))           res_ch ();
  tafc_stream_if #(.payload_t(logic [DUTY_W-1:0])) duty_ch ();

  fan_alarm_tracker tracker;
  int results_taken = 0;
  int cycle_count = 0;

  temperature_alarm_fan_controller_unit #(
    .PWM_PERIOD(PWM_PERIOD)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (req_ch),
    .result(res_ch),
    .cfg   (duty_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all during a steady stretch.
  function automatic int idle_cycles(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic item_t make_step(int temp, logic [2:0] pad, logic [2:0] btn);
    item_t req;
    req.command     = CMD_STEP;
    req.temperature = 12'(temp);
    req.pad_key     = pad;
    req.button_key  = btn;
    return req;
  endfunction

  function automatic item_t make_tick();
    item_t req;
    req = item_t'($urandom);
    req.command = CMD_TICK;
    return req;
  endfunction

  // Samples cluster around the current thresholds so that the compares flip often.
  function automatic item_t random_request(drift_e drift);
    item_t req;
    int    r;
    int    temp;
    r = $urandom_range(0, 99);
    if (r < 35) temp = tracker.high_deg * 16 + int'($urandom_range(0, 40)) - 20;
    else if (r < 65) temp = tracker.low_deg * 16 + int'($urandom_range(0, 40)) - 20;
    else temp = int'($urandom_range(0, 4095)) - 2048;
    req.command = ($urandom_range(0, 99) < 35) ? CMD_TICK : CMD_STEP;
    req.temperature = 12'(temp);
    r = $urandom_range(0, 99);
    case (drift)
      DRIFT_HIGH_UP:  req.pad_key = (r < 90) ? PAD_HIGH_UP : 3'($urandom_range(0, 7));
      DRIFT_LOW_DOWN: req.pad_key = (r < 90) ? PAD_LOW_DOWN : 3'($urandom_range(0, 7));
      DRIFT_SQUEEZE: begin
        if (r < 45) req.pad_key = PAD_HIGH_DOWN;
        else if (r < 90) req.pad_key = PAD_LOW_UP;
        else req.pad_key = 3'($urandom_range(0, 7));
      end
      default: req.pad_key = 3'($urandom_range(0, 7));
    endcase
    req.button_key = ($urandom_range(0, 99) < 80) ? BTN_NONE : 3'($urandom_range(0, 7));
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(item_t req, int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= req;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(req);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_fan_duty(logic [DUTY_W-1:0] value);
    duty_ch.valid <= 1'b1;
    duty_ch.data  <= value;
    do @(posedge clk); while (!duty_ch.ready);
    tracker.write_duty(value);
    @(negedge clk);
    duty_ch.valid <= 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        tracker.check_result(res_ch.data);
        results_taken++;
      end
    end
  end

  // Result side: random stalls, plus two long hold-offs that back up the block.
  initial begin
    int holds;
    int stall;
    holds = 0;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds < 2 && results_taken >= 400 + 800 * holds) begin
        res_ch.ready <= 1'b0;
        repeat (80) @(negedge clk);
        holds++;
      end else begin
        stall = idle_cycles(1'b0);
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
        else repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  initial begin
    logic [DUTY_W-1:0] phase_duty[6];
    drift_e drift_plan[8];
    drift_e drift;
    bit steady;
    int count;
    tracker = new();
    phase_duty = '{7'd0, 7'd100, 7'd99, 7'd1, 7'd127, 7'd0};
    phase_duty[5] = 7'($urandom_range(0, 127));
    drift_plan = '{DRIFT_HIGH_UP, DRIFT_HIGH_UP, DRIFT_LOW_DOWN, DRIFT_LOW_DOWN,
                   DRIFT_SQUEEZE, DRIFT_SQUEEZE, DRIFT_MIXED, DRIFT_MIXED};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    duty_ch.valid = 1'b0;
    duty_ch.data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A duty above the period keeps the motor on for the whole period.
    write_fan_duty(7'd127);
    send_request(make_tick(), 0);
    send_request(make_step(2047, PAD_FAN_MODE, BTN_NONE), 0);
    send_request(make_tick(), 1);
    send_request(make_tick(), 0);
    // Samples exactly on a threshold raise no alarm; one unit past it does.
    send_request(make_step(480, PAD_NONE, BTN_NONE), 0);
    send_request(make_step(481, PAD_NONE, BTN_NONE), 2);
    send_request(make_step(320, PAD_NONE, BTN_NONE), 0);
    send_request(make_step(319, PAD_NONE, BTN_NONE), 0);
    send_request(make_step(-2048, PAD_HIGH_UP, BTN_NONE), 0);
    send_request(make_step(0, PAD_HIGH_DOWN, BTN_NONE), 0);
    send_request(make_step(0, PAD_LOW_UP, BTN_NONE), 3);
    send_request(make_step(0, PAD_LOW_DOWN, BTN_NONE), 0);
    send_request(make_step(1000, 3'd5, BTN_NONE), 0);
    send_request(make_step(1000, 3'd6, BTN_NONE), 0);
    // A silenced alarm reports nothing even far out of range.
    send_request(make_step(2047, PAD_NONE, BTN_SILENT), 0);
    send_request(make_step(-2048, PAD_NONE, 3'd3), 0);
    send_request(make_step(-2048, PAD_NONE, BTN_AUDIBLE), 1);
    send_request(make_step(2047, PAD_NONE, BTN_AUTO), 0);
    send_request(make_step(2047, PAD_NONE, 3'd5), 0);
    send_request(make_step(2047, PAD_NONE, 3'd6), 0);
    send_request(make_step(2047, PAD_FAN_MODE, 3'd7), 0);
    send_request(make_tick(), 0);
    drain_requests();

    count = 0;
    steady = 1'b0;
    drift = drift_plan[0];
    for (int phase = 0; phase < 6; phase++) begin
      write_fan_duty(phase_duty[phase]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (count % SEGMENT_ITEMS == 0) begin
          drift = drift_plan[(count / SEGMENT_ITEMS) % 8];
          steady = ($urandom_range(0, 4) == 0);
        end
        send_request(random_request(drift), idle_cycles(steady));
        count++;
      end
      drain_requests();
    end

    repeat (8) @(negedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/tafc_pkg.sv
rtl/core/tafc_stream_if.sv
rtl/core/tafc_step.sv
rtl/core/temperature_alarm_fan_controller_unit.sv
test/tb.sv
